// ===== hw/rtl/event_control_block_table_unit_macros.svh =====
// assertion helpers, clocked on clk_i with rst_ni low as the disable
`ifndef EVENT_CONTROL_BLOCK_TABLE_UNIT_MACROS_SVH
`define EVENT_CONTROL_BLOCK_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define ECBT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ecbt_pkg.sv =====
package ecbt_pkg;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] arg_descriptor;
    logic [31:0] spec_word;
    logic [31:0] mode_word;
    logic [31:0] handler_addr;
  } ecbt_in_t;

  typedef struct packed {
    logic [31:0] return_value;
    logic        call_handler;
    logic [31:0] call_address;
    logic        index_error;
  } ecbt_out_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] mode;
    logic [31:0] handler;
  } ecbt_entry_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } ecbt_state_e;

  typedef struct packed {
    logic clr_en;
    logic load_in;
    logic rd_en;
    logic upd_en;
  } ecbt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } ecbt_stat_t;

  localparam logic [2:0] FN_OPEN      = 3'd0;
  localparam logic [2:0] FN_CLOSE     = 3'd1;
  localparam logic [2:0] FN_WAIT      = 3'd2;
  localparam logic [2:0] FN_TEST      = 3'd3;
  localparam logic [2:0] FN_ENABLE    = 3'd4;
  localparam logic [2:0] FN_DISABLE   = 3'd5;
  localparam logic [2:0] FN_DELIVER   = 3'd6;
  localparam logic [2:0] FN_UNDELIVER = 3'd7;

  localparam logic [1:0] ENT_UNUSED    = 2'd0;
  localparam logic [1:0] ENT_WAIT      = 2'd1;
  localparam logic [1:0] ENT_ACTIVE    = 2'd2;
  localparam logic [1:0] ENT_DELIVERED = 2'd3;

  localparam logic [0:0] CFG_INT_MODE   = 1'b0;
  localparam logic [0:0] CFG_NOINT_MODE = 1'b1;

  localparam logic [31:0] INT_MODE_RESET   = 32'h0000_1000;
  localparam logic [31:0] NOINT_MODE_RESET = 32'h0000_2000;

  localparam logic [3:0]  CLASS_ALIAS_IN  = 4'hf;
  localparam logic [3:0]  CLASS_ALIAS_OUT = 4'h5;
  localparam logic [31:0] SPEC_CODE_A     = 32'h0000_0301;
  localparam logic [31:0] SPEC_CODE_B     = 32'h0000_0302;
  localparam logic [4:0]  SPEC_COL_A      = 5'd16;
  localparam logic [4:0]  SPEC_COL_B      = 5'd17;

  // class times 32 plus the low five descriptor bits
  function automatic logic [8:0] class_row(input logic [31:0] d);
    logic [3:0] cls;
    cls = d[27:24];
    if (cls == CLASS_ALIAS_IN) begin
      cls = CLASS_ALIAS_OUT;
    end
    return {cls, d[4:0]};
  endfunction

  // lowest set bit of the low half, or one of the two codes
  function automatic logic [4:0] spec_col(input logic [31:0] s);
    logic [4:0] res;
    res = '0;
    if (s == SPEC_CODE_A) begin
      res = SPEC_COL_A;
    end else if (s == SPEC_CODE_B) begin
      res = SPEC_COL_B;
    end else begin
      for (int i = 15; i >= 0; i--) begin
        if (s[i]) begin
          res = 5'(i);
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/ecbt_ctrl.sv =====
`include "event_control_block_table_unit_macros.svh"

module ecbt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ecbt_pkg::ecbt_stat_t  stat_i,
  output ecbt_pkg::ecbt_cmd_t   cmd_o
);

  ecbt_pkg::ecbt_state_e state_q, state_d;
  logic                  ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecbt_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ecbt_pkg::S_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d = ecbt_pkg::S_IDLE;
        end
      end
      ecbt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ecbt_pkg::S_LOOKUP;
        end
      end
      ecbt_pkg::S_LOOKUP: begin
        state_d = ecbt_pkg::S_UPDATE;
      end
      ecbt_pkg::S_UPDATE: begin
        if (!stat_i.out_busy) begin
          state_d = in_valid_i ? ecbt_pkg::S_LOOKUP : ecbt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ecbt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    ready = 1'b0;
    unique case (state_q)
      ecbt_pkg::S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      ecbt_pkg::S_IDLE: begin
        ready = 1'b1;
      end
      ecbt_pkg::S_LOOKUP: begin
        cmd_o.rd_en = 1'b1;
      end
      ecbt_pkg::S_UPDATE: begin
        cmd_o.upd_en = !stat_i.out_busy;
        ready        = !stat_i.out_busy;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
    cmd_o.load_in = ready && in_valid_i;
  end

  assign in_stall_o = !ready;

  `ECBT_ASSERT_SAME(a_no_result_overrun, cmd_o.upd_en, !stat_i.out_busy, "result overrun")
  `ECBT_ASSERT_NEXT(a_lookup_then_update, state_q == ecbt_pkg::S_LOOKUP, state_q == ecbt_pkg::S_UPDATE, "lookup not followed by update")
  `ECBT_ASSERT_SAME(a_no_transfer_in_clear, state_q == ecbt_pkg::S_CLEAR, in_stall_o && !cmd_o.load_in, "transfer during clear")

endmodule

// ===== hw/rtl/ecbt_datapath.sv =====
`include "event_control_block_table_unit_macros.svh"

module ecbt_datapath #(
  parameter int unsigned EVENT_ROWS = 256,
  parameter int unsigned SPEC_COLS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ecbt_pkg::ecbt_in_t   in_data_i,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ecbt_pkg::ecbt_out_t  out_data_o,
  input  ecbt_pkg::ecbt_cmd_t  cmd_i,
  output ecbt_pkg::ecbt_stat_t stat_o
);

  localparam int unsigned DEPTH  = EVENT_ROWS * SPEC_COLS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [9:0]  ROWS_L = 10'(EVENT_ROWS);
  localparam logic [7:0]  COLS_L = 8'(SPEC_COLS);
  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(SPEC_COLS);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);

  ecbt_pkg::ecbt_entry_t mem [DEPTH];

  ecbt_pkg::ecbt_in_t    in_q;
  ecbt_pkg::ecbt_entry_t rd_q;
  ecbt_pkg::ecbt_entry_t wr_ent;
  ecbt_pkg::ecbt_out_t   out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic [31:0]           int_mode_q, noint_mode_q;
  logic [ADDR_W-1:0]     clr_q, clr_d;

  logic                  use_class;
  logic [8:0]            row;
  logic [7:0]            col;
  logic                  in_range;
  logic [ADDR_W-1:0]     addr;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  ecbt_pkg::ecbt_entry_t mem_wd;

  // item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_mode_q   <= ecbt_pkg::INT_MODE_RESET;
      noint_mode_q <= ecbt_pkg::NOINT_MODE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ecbt_pkg::CFG_INT_MODE:   int_mode_q   <= cfg_wdata_i;
        ecbt_pkg::CFG_NOINT_MODE: noint_mode_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // entry location
  always_comb begin
    use_class = (in_q.func == ecbt_pkg::FN_OPEN) || (in_q.func == ecbt_pkg::FN_DELIVER) ||
                (in_q.func == ecbt_pkg::FN_UNDELIVER);
    if (use_class) begin
      row = ecbt_pkg::class_row(in_q.arg_descriptor);
      col = 8'(ecbt_pkg::spec_col(in_q.spec_word));
    end else begin
      row = {1'b0, in_q.arg_descriptor[7:0]};
      col = in_q.arg_descriptor[15:8];
    end
    in_range = ({1'b0, row} < ROWS_L) && (col < COLS_L);
    addr     = in_range ? (ADDR_W'(row) * COLS_A + ADDR_W'(col)) : '0;
  end

  // entry update and result
  always_comb begin
    wr_ent = rd_q;
    out_d  = '0;
    if (!in_range) begin
      out_d.index_error = 1'b1;
    end else begin
      case (in_q.func)
        ecbt_pkg::FN_OPEN: begin
          wr_ent.status      = ecbt_pkg::ENT_WAIT;
          wr_ent.mode        = in_q.mode_word;
          wr_ent.handler     = in_q.handler_addr;
          out_d.return_value = 32'(row) | (32'(col) << 8);
        end
        ecbt_pkg::FN_CLOSE: begin
          wr_ent.status      = ecbt_pkg::ENT_UNUSED;
          out_d.return_value = 32'd1;
        end
        ecbt_pkg::FN_WAIT, ecbt_pkg::FN_ENABLE: begin
          wr_ent.status      = ecbt_pkg::ENT_ACTIVE;
          out_d.return_value = 32'd1;
        end
        ecbt_pkg::FN_TEST: begin
          if (rd_q.status == ecbt_pkg::ENT_DELIVERED) begin
            wr_ent.status      = ecbt_pkg::ENT_ACTIVE;
            out_d.return_value = 32'd1;
          end
        end
        ecbt_pkg::FN_DISABLE: begin
          wr_ent.status      = ecbt_pkg::ENT_WAIT;
          out_d.return_value = 32'd1;
        end
        ecbt_pkg::FN_DELIVER: begin
          if (rd_q.status == ecbt_pkg::ENT_ACTIVE) begin
            if (rd_q.mode == int_mode_q) begin
              out_d.call_handler = 1'b1;
              out_d.call_address = rd_q.handler;
            end else begin
              wr_ent.status = ecbt_pkg::ENT_DELIVERED;
            end
          end
        end
        default: begin
          if (rd_q.status == ecbt_pkg::ENT_DELIVERED && rd_q.mode == noint_mode_q) begin
            wr_ent.status = ecbt_pkg::ENT_ACTIVE;
          end
        end
      endcase
    end
  end

  // table port, shared by the clearing sweep and the update
  assign mem_we = cmd_i.clr_en || (cmd_i.upd_en && in_range);
  assign mem_wa = cmd_i.clr_en ? clr_q : addr;
  assign mem_wd = cmd_i.clr_en ? '0 : wr_ent;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[addr];
    end
  end

  assign clr_d = cmd_i.clr_en ? clr_q + 1'b1 : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // result register
  assign out_valid_d = cmd_i.upd_en || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign stat_o.clr_last = (clr_q == LAST_A);
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  `ECBT_ASSERT_NEXT(a_update_gives_result, cmd_i.upd_en, out_valid_q, "update lost its result")
  `ECBT_ASSERT_NEXT(a_clear_advances, cmd_i.clr_en && (clr_q != LAST_A), clr_q == $past(clr_q) + 1'b1, "clear sweep stalled")
  `ECBT_ASSERT_SAME(a_error_result_empty, out_valid_q && out_q.index_error, !out_q.call_handler && (out_q.return_value == 32'd0) && (out_q.call_address == 32'd0), "error result not empty")

endmodule

// ===== hw/rtl/event_control_block_table_unit.sv =====
// event control block table
// input channel: in_valid_i / in_stall_o with in_data_i, one service call per
// transfer (open, close, wait, test, enable, disable, deliver, undeliver)
// output channel: out_valid_o / out_stall_i with out_data_o, one result per call
// configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 interrupt mode code, 1 no-interrupt mode code), taken at once
// sequence: a call passes the lookup and update states, then its result is
// registered; a new call is taken at the earliest in the update state of the
// last one, as the single table port is read in lookup and written in update
// reset: a clearing sweep writes every table entry, EVENT_ROWS * SPEC_COLS
// of them (8192 at the defaults), with in_stall_o high throughout
// stall: a waiting result is held in the output register; one further call
// may be taken and worked up to its update, then in_stall_o stays high until
// the waiting result is transferred
module event_control_block_table_unit #(
  parameter int unsigned EVENT_ROWS = 256,
  parameter int unsigned SPEC_COLS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ecbt_pkg::ecbt_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ecbt_pkg::ecbt_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i
);

  ecbt_pkg::ecbt_cmd_t  cmd;
  ecbt_pkg::ecbt_stat_t stat;

  ecbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ecbt_datapath #(
    .EVENT_ROWS (EVENT_ROWS),
    .SPEC_COLS  (SPEC_COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
